// File: src/cfm_pkg.sv
// package for the catapult fire mode controller
// holds clock width, mode and phase codes, register indexes and reset values
// no dependencies
package cfm_pkg;

  // millisecond clock width and the width used to compare it with guard_ms
  localparam int CLOCK_BITS = 16;
  localparam int CMP_BITS   = (CLOCK_BITS > 16) ? CLOCK_BITS : 16;

  // field and register widths
  localparam int ANGLE_BITS = 9;
  localparam int DIST_BITS  = 12;
  localparam int GUARD_BITS = 16;
  localparam int POWER_BITS = 7;
  localparam int TICK_BITS  = 8;
  localparam int MODE_BITS  = 3;
  localparam int PHASE_BITS = 2;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;

  typedef logic [MODE_BITS-1:0]  mode_t;
  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic [CLOCK_BITS-1:0] clock_t;

  // mode codes
  localparam mode_t MODE_LOADING   = 3'd0;
  localparam mode_t MODE_RESETTING = 3'd1;
  localparam mode_t MODE_AUTOFIRE  = 3'd2;
  localparam mode_t MODE_WAITING   = 3'd3;
  localparam mode_t MODE_DISTFIRE  = 3'd4;

  // phase codes
  localparam phase_t PH_START = 2'd0;
  localparam phase_t PH_IDLE  = 2'd1;
  localparam phase_t PH_AUTO  = 2'd2;
  localparam phase_t PH_SEMI  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_RESET_ANGLE  = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RETURN_ANGLE = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GUARD        = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BALL_NEAR    = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RESET_POWER  = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRE_POWER   = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_AUTO_POWER   = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_TICK         = 4'd7;

  // register reset values
  localparam logic [ANGLE_BITS-1:0] RST_RESET_ANGLE  = 9'd80;
  localparam logic [ANGLE_BITS-1:0] RST_RETURN_ANGLE = 9'd75;
  localparam logic [GUARD_BITS-1:0] RST_GUARD        = 16'd200;
  localparam logic [DIST_BITS-1:0]  RST_BALL_NEAR    = 12'd50;
  localparam logic [POWER_BITS-1:0] RST_RESET_POWER  = 7'd90;
  localparam logic [POWER_BITS-1:0] RST_FIRE_POWER   = 7'd127;
  localparam logic [POWER_BITS-1:0] RST_AUTO_POWER   = 7'd114;
  localparam logic [TICK_BITS-1:0]  RST_TICK         = 8'd20;

endpackage

// File: src/catapult_fire_mode_controller_top.sv
// catapult fire mode controller, top level
// one control tick per request: input register, tick logic, result register
// depends on cfm_pkg
//
// usage:
//   input channel in_valid / in_stall carries one control tick per request:
//   auto_button, semi_button, arm_angle_deg, ball_distance_mm.
//   output channel out_valid / out_stall returns one result per tick:
//   motor_power, mode_code and phase_code after that tick.
//   a request is taken at a rising edge with valid high and stall low.
//   a taken request moves through the tick logic into the result register at
//   the next advance, which raises out_valid; an output stall can hold that
//   advance back. the receiver takes the result at an edge with out_stall low.
//   throughput is one tick per cycle when out_stall is low; the state update
//   (phase, mode, locks, clock) is done as the tick enters the result register.
//   when the receiver stalls, the result holds and one more tick can wait in
//   the input register; then in_stall rises.
//   reset (rst, synchronous) clears state to phase 0, mode loading, locks and
//   clock zero, loads the register defaults and empties both stages.
//   configuration writes (cfg_write, cfg_index, cfg_data) take effect at once;
//   indexes beyond the register list are ignored.
module catapult_fire_mode_controller_top (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [cfm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [cfm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                auto_button,
  input  logic                                semi_button,
  input  logic [cfm_pkg::ANGLE_BITS-1:0]      arm_angle_deg,
  input  logic [cfm_pkg::DIST_BITS-1:0]       ball_distance_mm,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cfm_pkg::POWER_BITS-1:0]      motor_power,
  output logic [cfm_pkg::MODE_BITS-1:0]       mode_code,
  output logic [cfm_pkg::PHASE_BITS-1:0]      phase_code
);

  // configuration registers
  logic [cfm_pkg::ANGLE_BITS-1:0] reset_angle_deg;
  logic [cfm_pkg::ANGLE_BITS-1:0] return_angle_deg;
  logic [cfm_pkg::GUARD_BITS-1:0] guard_ms;
  logic [cfm_pkg::DIST_BITS-1:0]  ball_near_mm;
  logic [cfm_pkg::POWER_BITS-1:0] reset_power;
  logic [cfm_pkg::POWER_BITS-1:0] fire_power;
  logic [cfm_pkg::POWER_BITS-1:0] auto_power;
  logic [cfm_pkg::TICK_BITS-1:0]  tick_ms;

  // controller state
  cfm_pkg::phase_t phase, phase_next;
  cfm_pkg::mode_t  mode, mode_next;
  logic            auto_lock, auto_lock_next;
  logic            semi_lock, semi_lock_next;
  cfm_pkg::clock_t clock_ms, clock_ms_next;

  // input register
  logic                           in_full;
  logic                           in_auto;
  logic                           in_semi;
  logic [cfm_pkg::ANGLE_BITS-1:0] in_angle;
  logic [cfm_pkg::DIST_BITS-1:0]  in_dist;

  // tick logic signals
  logic                           advance;
  logic                           take;
  logic                           auto_press;
  logic                           semi_press;
  logic                           guard_passed;
  cfm_pkg::clock_t                clock_base;
  logic [cfm_pkg::CLOCK_BITS:0]   clock_sum;
  logic [cfm_pkg::POWER_BITS-1:0] power_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_angle_deg  <= cfm_pkg::RST_RESET_ANGLE;
      return_angle_deg <= cfm_pkg::RST_RETURN_ANGLE;
      guard_ms         <= cfm_pkg::RST_GUARD;
      ball_near_mm     <= cfm_pkg::RST_BALL_NEAR;
      reset_power      <= cfm_pkg::RST_RESET_POWER;
      fire_power       <= cfm_pkg::RST_FIRE_POWER;
      auto_power       <= cfm_pkg::RST_AUTO_POWER;
      tick_ms          <= cfm_pkg::RST_TICK;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cfm_pkg::REG_RESET_ANGLE:  reset_angle_deg  <= cfg_data[cfm_pkg::ANGLE_BITS-1:0];
        cfm_pkg::REG_RETURN_ANGLE: return_angle_deg <= cfg_data[cfm_pkg::ANGLE_BITS-1:0];
        cfm_pkg::REG_GUARD:        guard_ms         <= cfg_data[cfm_pkg::GUARD_BITS-1:0];
        cfm_pkg::REG_BALL_NEAR:    ball_near_mm     <= cfg_data[cfm_pkg::DIST_BITS-1:0];
        cfm_pkg::REG_RESET_POWER:  reset_power      <= cfg_data[cfm_pkg::POWER_BITS-1:0];
        cfm_pkg::REG_FIRE_POWER:   fire_power       <= cfg_data[cfm_pkg::POWER_BITS-1:0];
        cfm_pkg::REG_AUTO_POWER:   auto_power       <= cfg_data[cfm_pkg::POWER_BITS-1:0];
        cfm_pkg::REG_TICK:         tick_ms          <= cfg_data[cfm_pkg::TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: a tick moves on when the result register is empty or its result is being taken
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign take     = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_auto  <= auto_button;
      in_semi  <= semi_button;
      in_angle <= arm_angle_deg;
      in_dist  <= ball_distance_mm;
    end
  end

  // fresh presses and the guard time check
  assign auto_press   = in_auto && !auto_lock;
  assign semi_press   = in_semi && !semi_lock;
  assign guard_passed = cfm_pkg::CMP_BITS'(clock_ms) > cfm_pkg::CMP_BITS'(guard_ms);

  // phase logic, lock release, clock clear
  always_comb begin
    phase_next     = phase;
    mode_next      = mode;
    auto_lock_next = auto_lock;
    semi_lock_next = semi_lock;
    clock_base     = clock_ms;
    unique case (phase)
      cfm_pkg::PH_START: begin
        if (in_angle >= reset_angle_deg) begin
          mode_next = cfm_pkg::MODE_RESETTING;
        end else begin
          mode_next  = cfm_pkg::MODE_LOADING;
          phase_next = cfm_pkg::PH_IDLE;
        end
      end
      cfm_pkg::PH_IDLE: begin
        if (mode == cfm_pkg::MODE_RESETTING && in_angle < reset_angle_deg && guard_passed) begin
          mode_next = cfm_pkg::MODE_LOADING;
        end else if (auto_press) begin
          phase_next     = cfm_pkg::PH_AUTO;
          auto_lock_next = 1'b1;
        end else if (semi_press) begin
          phase_next     = cfm_pkg::PH_SEMI;
          semi_lock_next = 1'b1;
          mode_next      = cfm_pkg::MODE_WAITING;
        end
      end
      cfm_pkg::PH_AUTO: begin
        mode_next = cfm_pkg::MODE_AUTOFIRE;
        if (auto_press) begin
          phase_next     = cfm_pkg::PH_START;
          auto_lock_next = 1'b1;
        end
      end
      cfm_pkg::PH_SEMI: begin
        if (mode == cfm_pkg::MODE_DISTFIRE && in_angle <= return_angle_deg && guard_passed) begin
          clock_base = '0;
          mode_next  = cfm_pkg::MODE_WAITING;
        end else if (mode == cfm_pkg::MODE_WAITING && in_dist < ball_near_mm) begin
          mode_next  = cfm_pkg::MODE_DISTFIRE;
          clock_base = '0;
        end
        if (semi_press) begin
          phase_next     = cfm_pkg::PH_START;
          semi_lock_next = 1'b1;
        end
      end
      default: ;
    endcase
    if (!in_auto) begin
      auto_lock_next = 1'b0;
    end
    if (!in_semi) begin
      semi_lock_next = 1'b0;
    end
    if (in_semi) begin
      clock_base = '0;
    end
  end

  // saturating clock advance
  assign clock_sum     = {1'b0, clock_base} + (cfm_pkg::CLOCK_BITS+1)'(tick_ms);
  assign clock_ms_next = clock_sum[cfm_pkg::CLOCK_BITS] ? '1
                                                        : clock_sum[cfm_pkg::CLOCK_BITS-1:0];

  // motor power for the new mode
  always_comb begin
    case (mode_next)
      cfm_pkg::MODE_RESETTING: power_next = reset_power;
      cfm_pkg::MODE_AUTOFIRE:  power_next = auto_power;
      cfm_pkg::MODE_DISTFIRE:  power_next = fire_power;
      default:                 power_next = '0;
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= cfm_pkg::PH_START;
      mode      <= cfm_pkg::MODE_LOADING;
      auto_lock <= 1'b0;
      semi_lock <= 1'b0;
      clock_ms  <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      mode      <= mode_next;
      auto_lock <= auto_lock_next;
      semi_lock <= semi_lock_next;
      clock_ms  <= clock_ms_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      motor_power <= power_next;
      mode_code   <= mode_next;
      phase_code  <= phase_next;
    end
  end

  // auto phase always lands in autofire mode
  a_auto_mode: assert property (@(posedge clk) disable iff (rst)
    (advance && phase == cfm_pkg::PH_AUTO) |=> mode == cfm_pkg::MODE_AUTOFIRE)
    else $error("auto phase did not give autofire mode");

  // holding semi restarts the clock from one tick
  a_semi_clock: assert property (@(posedge clk) disable iff (rst)
    (advance && in_semi) |=> clock_ms == cfm_pkg::CLOCK_BITS'(tick_ms))
    else $error("clock not restarted while semi held");

  // start check with a low arm goes to idle in loading mode
  a_start_low: assert property (@(posedge clk) disable iff (rst)
    (advance && phase == cfm_pkg::PH_START && in_angle < reset_angle_deg)
    |=> (phase == cfm_pkg::PH_IDLE && mode == cfm_pkg::MODE_LOADING))
    else $error("start check did not reach idle");

  // result register and state move together
  a_result_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_valid && mode_code == mode && phase_code == phase))
    else $error("result does not match state");

  // an empty input register never stalls the sender
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> !in_stall)
    else $error("stall with empty input register");

endmodule
